FILE: rtl/gtc_pkg.sv
// gtc_pkg: shared types and constants for the glyph tag cache
// used by gtc_ctrl, gtc_datapath and glyph_tag_cache_round_robin
package gtc_pkg;

  // default geometry
  localparam int unsigned FONT_SET_BITS_DEF = 3;
  localparam int unsigned CODE_SET_BITS_DEF = 6;
  localparam int unsigned WAYS_DEF          = 16;

  // tag field widths
  localparam int unsigned CODE_W = 21;
  localparam int unsigned FONT_W = 16;
  localparam int unsigned KIND_W = 16;
  localparam int unsigned REQ_W  = 2;

  // input word layout, lowest bit first
  localparam int unsigned IN_CODE_LSB = 0;
  localparam int unsigned IN_FONT_LSB = IN_CODE_LSB + CODE_W;
  localparam int unsigned IN_KIND_LSB = IN_FONT_LSB + FONT_W;
  localparam int unsigned IN_BITS     = IN_KIND_LSB + KIND_W;
  localparam int unsigned IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

  // request codes
  localparam logic [REQ_W-1:0] REQ_LOOKUP  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_INIT    = 2'd2;
  localparam logic [REQ_W-1:0] REQ_DISABLE = 2'd3;

  // one stored tag
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [FONT_W-1:0] font;
    logic [CODE_W-1:0] code;
  } tag_t;

  // controller to datapath
  typedef struct packed {
    logic load_req;     // latch request and read its set
    logic issue;        // produce the result word, do the allocate write
    logic enabled;      // cache enabled while issuing
    logic sweep_start;  // restart the clearing sweep
    logic sweep_wr;     // clear one set and step the sweep
  } gtc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             out_free;
    logic             sweep_last;
  } gtc_stat_t;

endpackage

FILE: rtl/gtc_ctrl.sv
// gtc_ctrl: request sequencer and enabled flag of the glyph tag cache
// depends on gtc_pkg
module gtc_ctrl
  import gtc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  gtc_stat_t stat_i,
  output gtc_cmd_t  cmd_o
);

  localparam logic [1:0] ST_SWEEP = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       enabled_q, enabled_d;
  logic       resp_q, resp_d;

  // state registers, reset starts with a clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_SWEEP;
      enabled_q <= 1'b0;
      resp_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      enabled_q <= enabled_d;
      resp_q    <= resp_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d           = state_q;
    enabled_d         = enabled_q;
    resp_d            = resp_q;
    cmd_o             = '0;
    cmd_o.enabled     = enabled_q;
    in_ready_o        = 1'b0;
    unique case (state_q)
      ST_SWEEP: begin
        cmd_o.sweep_wr = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = resp_q ? ST_EXEC : ST_IDLE;
          resp_d  = 1'b0;
        end
      end
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_req = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat_i.req_type == REQ_INIT && !enabled_q) begin
          // clear everything first, the init word follows the sweep
          enabled_d         = 1'b1;
          resp_d            = 1'b1;
          cmd_o.sweep_start = 1'b1;
          state_d           = ST_SWEEP;
        end else if (stat_i.out_free) begin
          cmd_o.issue = 1'b1;
          state_d     = ST_IDLE;
          if (stat_i.req_type == REQ_DISABLE) begin
            enabled_d = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/gtc_datapath.sv
// gtc_datapath: tag and pointer memories, way compare and result register
// depends on gtc_pkg, driven by gtc_ctrl
module gtc_datapath
  import gtc_pkg::*;
#(
  parameter int unsigned FONT_SET_BITS = FONT_SET_BITS_DEF,
  parameter int unsigned CODE_SET_BITS = CODE_SET_BITS_DEF,
  parameter int unsigned WAYS          = WAYS_DEF,
  parameter int unsigned WAY_W         = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  gtc_cmd_t                 cmd_i,
  output gtc_stat_t                stat_o,
  input  logic [REQ_W-1:0]         req_type_i,
  input  logic [CODE_W-1:0]        code_point_i,
  input  logic [FONT_W-1:0]        font_key_i,
  input  logic [KIND_W-1:0]        glyph_kind_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     hit_o,
  output logic [FONT_SET_BITS-1:0] font_bucket_o,
  output logic [CODE_SET_BITS-1:0] code_bucket_o,
  output logic [WAY_W-1:0]         way_index_o
);

  localparam int unsigned SET_W     = FONT_SET_BITS + CODE_SET_BITS;
  localparam int unsigned SET_COUNT = 1 << SET_W;
  localparam logic [WAY_W:0] WAYS_N = (WAY_W + 1)'(WAYS);

  // memories, one row per set
  tag_t             tag_mem [SET_COUNT][WAYS];
  logic [WAY_W-1:0] ptr_mem [SET_COUNT];

  // request registers and read data
  logic [REQ_W-1:0]         req_q;
  tag_t                     tag_q;
  logic [FONT_SET_BITS-1:0] fb_q;
  logic [CODE_SET_BITS-1:0] cb_q;
  tag_t                     row_q [WAYS];
  logic [WAY_W-1:0]         ptr_q;

  logic [SET_W-1:0]         sweep_cnt_q;
  logic                     out_valid_q;
  logic                     out_hit_q;
  logic [FONT_SET_BITS-1:0] out_fb_q;
  logic [CODE_SET_BITS-1:0] out_cb_q;
  logic [WAY_W-1:0]         out_way_q;

  logic [FONT_SET_BITS-1:0] fb_in;
  logic [CODE_SET_BITS-1:0] cb_in;
  logic [WAYS-1:0]          match;
  logic                     look_hit;
  logic [WAY_W-1:0]         look_way;
  logic [WAY_W-1:0]         alloc_way;
  logic [WAY_W-1:0]         next_ptr;
  logic                     alloc_wr;
  logic                     res_hit;
  logic [WAY_W-1:0]         res_way;

  // set index of the incoming word
  assign fb_in = font_key_i[FONT_SET_BITS-1:0] ^ code_point_i[FONT_SET_BITS-1:0];
  assign cb_in = code_point_i[CODE_SET_BITS-1:0];

  // latch the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q      <= req_type_i;
      tag_q.code <= code_point_i;
      tag_q.font <= font_key_i;
      tag_q.kind <= glyph_kind_i;
      fb_q       <= fb_in;
      cb_q       <= cb_in;
    end
  end

  // way compare over the read row
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = (row_q[w].code == tag_q.code) && (row_q[w].font == tag_q.font) &&
                 ((tag_q.kind == '0) || (row_q[w].kind == tag_q.kind));
    end
  end

  // lowest matching way wins
  always_comb begin
    look_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        look_way = WAY_W'(w);
      end
    end
  end
  assign look_hit = |match;

  // round-robin victim and its successor
  assign alloc_way = ({1'b0, ptr_q} >= WAYS_N) ? '0 : ptr_q;
  assign next_ptr  = (({1'b0, alloc_way} + 1'b1) == WAYS_N) ? '0 : alloc_way + 1'b1;
  assign alloc_wr  = cmd_i.issue && cmd_i.enabled && (req_q == REQ_ALLOC);

  // result selection
  always_comb begin
    res_hit = 1'b0;
    res_way = '0;
    if (cmd_i.enabled) begin
      if (req_q == REQ_LOOKUP) begin
        res_hit = look_hit;
        res_way = look_way;
      end else if (req_q == REQ_ALLOC) begin
        res_hit = 1'b1;
        res_way = alloc_way;
      end
    end
  end

  // tag memory: sweep clears a row, allocate writes one way
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_wr) begin
      for (int w = 0; w < WAYS; w++) begin
        tag_mem[sweep_cnt_q][w] <= '0;
      end
    end else if (alloc_wr) begin
      tag_mem[{fb_q, cb_q}][alloc_way] <= tag_q;
    end
    if (cmd_i.load_req) begin
      row_q <= tag_mem[{fb_in, cb_in}];
    end
  end

  // pointer memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_wr) begin
      ptr_mem[sweep_cnt_q] <= '0;
    end else if (alloc_wr) begin
      ptr_mem[{fb_q, cb_q}] <= next_ptr;
    end
    if (cmd_i.load_req) begin
      ptr_q <= ptr_mem[{fb_in, cb_in}];
    end
  end

  // sweep counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.sweep_start) begin
        sweep_cnt_q <= '0;
      end else if (cmd_i.sweep_wr) begin
        sweep_cnt_q <= sweep_cnt_q + 1'b1;
      end
      if (cmd_i.issue) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result word register, buckets zeroed on a miss
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      out_hit_q <= res_hit;
      out_fb_q  <= res_hit ? fb_q : '0;
      out_cb_q  <= res_hit ? cb_q : '0;
      out_way_q <= res_way;
    end
  end

  assign stat_o.req_type   = req_q;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;
  assign stat_o.sweep_last = &sweep_cnt_q;

  assign out_valid_o   = out_valid_q;
  assign hit_o         = out_hit_q;
  assign font_bucket_o = out_fb_q;
  assign code_bucket_o = out_cb_q;
  assign way_index_o   = out_way_q;

endmodule

FILE: rtl/glyph_tag_cache_round_robin.sv
// Set-associative glyph tag cache with round-robin replacement. A lookup,
// allocate or disable word passes an accept state and an execute state. The
// accepting edge reads the whole set row (all ways and the victim pointer)
// from single-port memories. In the next cycle every way is compared. When
// the result register is free, it loads and, for an allocate, the tag and
// the advanced pointer are written back, at the end of the execute state;
// the next word can be accepted after that. An init word while the cache is
// enabled takes the same path. After reset, and for an init word while the
// cache is disabled, a clearing pass writes zeros to one set per cycle, over
// all 2**(FONT_SET_BITS+CODE_SET_BITS) sets (512 at the defaults). No word is
// accepted during the pass, and the init result follows it. Results wait in an
// output register, so a new word is taken while one waits. The compare cycle
// then holds until that register is free.
// Depends on gtc_pkg, gtc_ctrl and gtc_datapath.
module glyph_tag_cache_round_robin
  import gtc_pkg::*;
#(
  parameter int unsigned FONT_SET_BITS = FONT_SET_BITS_DEF,
  parameter int unsigned CODE_SET_BITS = CODE_SET_BITS_DEF,
  parameter int unsigned WAYS          = WAYS_DEF,
  parameter int unsigned WAY_W         = (WAYS > 1) ? $clog2(WAYS) : 1,
  parameter int unsigned OUT_BITS      = FONT_SET_BITS + CODE_SET_BITS + WAY_W,
  parameter int unsigned OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // code_point, font_key, glyph_kind, zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // req_type
  input  logic [REQ_W-1:0]       s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // font_bucket, code_bucket, way_index, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // hit
  output logic [0:0]             m_axis_tuser
);

  gtc_cmd_t                 cmd;
  gtc_stat_t                stat;
  logic                     hit;
  logic [FONT_SET_BITS-1:0] font_bucket;
  logic [CODE_SET_BITS-1:0] code_bucket;
  logic [WAY_W-1:0]         way_index;

  gtc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gtc_datapath #(
    .FONT_SET_BITS (FONT_SET_BITS),
    .CODE_SET_BITS (CODE_SET_BITS),
    .WAYS          (WAYS),
    .WAY_W         (WAY_W)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .req_type_i    (s_axis_tuser),
    .code_point_i  (s_axis_tdata[IN_CODE_LSB +: CODE_W]),
    .font_key_i    (s_axis_tdata[IN_FONT_LSB +: FONT_W]),
    .glyph_kind_i  (s_axis_tdata[IN_KIND_LSB +: KIND_W]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .hit_o         (hit),
    .font_bucket_o (font_bucket),
    .code_bucket_o (code_bucket),
    .way_index_o   (way_index)
  );

  // pack the result word
  assign m_axis_tdata = OUT_TDATA_W'({way_index, code_bucket, font_bucket});
  assign m_axis_tuser = hit;

endmodule

FILE: tb/sv/tb_glyph_tag_cache_round_robin.sv
`timescale 1ns / 1ps
// tb_glyph_tag_cache_round_robin: self-checking stream testbench for the glyph tag cache
// holds its own cache predictor; depends on gtc_pkg and glyph_tag_cache_round_robin
module tb_glyph_tag_cache_round_robin;
  import gtc_pkg::*;

  localparam int unsigned FSB      = FONT_SET_BITS_DEF;
  localparam int unsigned CSB      = CODE_SET_BITS_DEF;
  localparam int unsigned NWAYS    = WAYS_DEF;
  localparam int unsigned WAYB     = $clog2(NWAYS);
  localparam int unsigned NSETS    = 1 << (FSB + CSB);
  localparam int unsigned OUT_W    = ((FSB + CSB + WAYB + 7) / 8) * 8;
  localparam int unsigned CODE_MAX = 21'h10FFFF;
  localparam int unsigned PHASE_N  = 278;

  // one request word
  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [CODE_W-1:0] code;
    logic [FONT_W-1:0] font;
    logic [KIND_W-1:0] kind;
  } glyph_req_t;

  // one result word
  typedef struct packed {
    logic            hit;
    logic [FSB-1:0]  fbkt;
    logic [CSB-1:0]  cbkt;
    logic [WAYB-1:0] way;
  } slot_res_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [REQ_W-1:0]      s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic [0:0]            m_axis_tuser;

  // predictor state
  tag_t            shadow_tags [NSETS][NWAYS];
  logic [WAYB-1:0] shadow_victim [NSETS];
  bit              shadow_on;

  glyph_req_t pending_reqs[$];
  slot_res_t  expected_slots[$];
  glyph_req_t tag_pool[$];
  int         reinit_countdown = -1;
  int         send_idle_pct    = 14;
  int         recv_idle_pct    = 79;
  int         mismatch_count   = 0;
  bit         req_fire         = 1'b0;

  glyph_tag_cache_round_robin i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // expected slot for one request, updates the shadow cache
  function automatic slot_res_t cache_predict(glyph_req_t r);
    slot_res_t       res;
    logic [FSB-1:0]  fb;
    logic [CSB-1:0]  cb;
    int unsigned     set_idx;
    logic [WAYB-1:0] w;
    res     = '0;
    fb      = FSB'(r.font ^ FONT_W'(r.code));
    cb      = r.code[CSB-1:0];
    set_idx = {fb, cb};
    case (r.req)
      REQ_INIT: begin
        if (!shadow_on) begin
          for (int s = 0; s < NSETS; s++) begin
            shadow_victim[s] = '0;
            for (int k = 0; k < NWAYS; k++) shadow_tags[s][k] = '0;
          end
        end
        shadow_on = 1'b1;
      end
      REQ_DISABLE: shadow_on = 1'b0;
      REQ_LOOKUP: begin
        if (shadow_on) begin
          for (int k = 0; k < NWAYS; k++) begin
            if (!res.hit && shadow_tags[set_idx][k].code == r.code &&
                shadow_tags[set_idx][k].font == r.font &&
                (r.kind == '0 || shadow_tags[set_idx][k].kind == r.kind)) begin
              res = '{hit: 1'b1, fbkt: fb, cbkt: cb, way: WAYB'(k)};
            end
          end
        end
      end
      default: begin
        // allocate: take the victim way, then advance with wrap
        if (shadow_on) begin
          w = shadow_victim[set_idx];
          shadow_tags[set_idx][w] = '{kind: r.kind, font: r.font, code: r.code};
          shadow_victim[set_idx] = (w == WAYB'(NWAYS - 1)) ? '0 : w + 1'b1;
          res = '{hit: 1'b1, fbkt: fb, cbkt: cb, way: w};
        end
      end
    endcase
    return res;
  endfunction

  // tag aimed at a handful of sets so ways wrap often
  function automatic glyph_req_t random_tag(logic [REQ_W-1:0] req);
    glyph_req_t r;
    r.req  = req;
    r.code = CODE_W'($urandom_range(0, CODE_MAX));
    r.font = FONT_W'($urandom);
    r.kind = KIND_W'($urandom);
    if ($urandom_range(0, 4) != 0) begin
      r.code[CSB-1:0] = CSB'($urandom_range(0, 3));
      r.font[FSB-1:0] = r.code[FSB-1:0] ^ FSB'($urandom_range(0, 1));
    end
    return r;
  endfunction

  // random request mix, mostly allocate then look up the same tags
  function automatic glyph_req_t random_req();
    glyph_req_t r;
    int         pick;
    pick = $urandom_range(0, 99);
    r    = random_tag(REQ_LOOKUP);
    if (reinit_countdown == 0) begin
      r.req = REQ_INIT;
      reinit_countdown = -1;
    end else begin
      if (reinit_countdown > 0) reinit_countdown--;
      if (pick < 1) begin
        r.req = REQ_INIT;
      end else if (pick < 3) begin
        r.req = REQ_DISABLE;
        reinit_countdown = $urandom_range(1, 5);
      end else if (pick < 40) begin
        r.req = REQ_ALLOC;
        if (tag_pool.size() > 0 && $urandom_range(0, 9) == 0) begin
          r = tag_pool[$urandom_range(0, tag_pool.size() - 1)];
          r.req = REQ_ALLOC;
        end
        tag_pool.push_back(r);
        if (tag_pool.size() > 64) void'(tag_pool.pop_front());
      end else if (pick < 85 && tag_pool.size() > 0) begin
        r = tag_pool[$urandom_range(0, tag_pool.size() - 1)];
        r.req = REQ_LOOKUP;
        case ($urandom_range(0, 4))
          0, 1:    r.kind = '0;
          2:       r.kind = KIND_W'($urandom);
          default: ;
        endcase
      end else if (pick >= 92) begin
        // cleared ways hold the all-zero tag
        r.code = '0;
        r.font = '0;
        r.kind = $urandom_range(0, 1) ? '0 : KIND_W'($urandom);
      end
    end
    return r;
  endfunction

  function automatic glyph_req_t mk_req(logic [REQ_W-1:0] req, int unsigned code,
                                        int unsigned font, int unsigned kind);
    glyph_req_t r;
    r = '{req: req, code: CODE_W'(code), font: FONT_W'(font), kind: KIND_W'(kind)};
    return r;
  endfunction

  // request driver, changes at the falling edge
  always @(negedge clk_i) begin
    logic       nxt_valid;
    glyph_req_t nxt;
    nxt_valid = s_axis_tvalid;
    nxt       = '{req: s_axis_tuser, code: s_axis_tdata[CODE_W-1:0],
                  font: s_axis_tdata[IN_FONT_LSB +: FONT_W],
                  kind: s_axis_tdata[IN_KIND_LSB +: KIND_W]};
    if (rst_ni && (!s_axis_tvalid || req_fire)) begin
      nxt_valid = 1'b0;
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt       = pending_reqs.pop_front();
        nxt_valid = 1'b1;
      end
    end
    s_axis_tvalid <= nxt_valid;
    s_axis_tuser  <= nxt.req;
    s_axis_tdata  <= IN_TDATA_W'({nxt.kind, nxt.font, nxt.code});
    m_axis_tready <= rst_ni && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk_i) begin
    glyph_req_t got_req;
    slot_res_t  got, want;
    req_fire = rst_ni && s_axis_tvalid && s_axis_tready;
    if (req_fire) begin
      got_req = '{req: s_axis_tuser, code: s_axis_tdata[CODE_W-1:0],
                  font: s_axis_tdata[IN_FONT_LSB +: FONT_W],
                  kind: s_axis_tdata[IN_KIND_LSB +: KIND_W]};
      expected_slots.push_back(cache_predict(got_req));
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{hit: m_axis_tuser[0], fbkt: m_axis_tdata[FSB-1:0],
              cbkt: m_axis_tdata[FSB +: CSB], way: m_axis_tdata[FSB+CSB +: WAYB]};
      if (expected_slots.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result word hit=%0b fb=%0d cb=%0d way=%0d",
                   $time, got.hit, got.fbkt, got.cbkt, got.way);
      end else begin
        want = expected_slots.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display(
              "%0t: mismatch exp hit=%0b fb=%0d cb=%0d way=%0d, got hit=%0b fb=%0d cb=%0d way=%0d",
              $time, want.hit, want.fbkt, want.cbkt, want.way,
              got.hit, got.fbkt, got.cbkt, got.way);
        end
      end
    end
  end

  // stimulus: directed words, then three random phases
  initial begin
    shadow_on = 1'b0;
    for (int s = 0; s < NSETS; s++) begin
      shadow_victim[s] = '0;
      for (int k = 0; k < NWAYS; k++) shadow_tags[s][k] = '0;
    end
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // disabled cache, clearing init, zero tag, extremes, duplicates, re-init
    pending_reqs.push_back(mk_req(REQ_LOOKUP, 0, 0, 0));
    pending_reqs.push_back(mk_req(REQ_ALLOC, 5, 7, 9));
    pending_reqs.push_back(mk_req(REQ_INIT, 0, 0, 0));
    pending_reqs.push_back(mk_req(REQ_LOOKUP, 0, 0, 0));
    pending_reqs.push_back(mk_req(REQ_LOOKUP, 0, 0, 16'hFFFF));
    pending_reqs.push_back(mk_req(REQ_ALLOC, CODE_MAX, 16'hFFFF, 16'hFFFF));
    pending_reqs.push_back(mk_req(REQ_LOOKUP, CODE_MAX, 16'hFFFF, 16'hFFFF));
    pending_reqs.push_back(mk_req(REQ_LOOKUP, CODE_MAX, 16'hFFFF, 0));
    pending_reqs.push_back(mk_req(REQ_LOOKUP, CODE_MAX, 16'hFFFF, 1));
    pending_reqs.push_back(mk_req(REQ_ALLOC, CODE_MAX, 16'hFFFF, 16'hFFFF));
    pending_reqs.push_back(mk_req(REQ_LOOKUP, CODE_MAX, 16'hFFFF, 0));
    pending_reqs.push_back(mk_req(REQ_ALLOC, 21'h0AAAAA, 16'h5555, 16'h8001));
    pending_reqs.push_back(mk_req(REQ_ALLOC, 21'h055555, 16'hAAAA, 16'h7FFE));
    pending_reqs.push_back(mk_req(REQ_INIT, 1, 2, 3));
    pending_reqs.push_back(mk_req(REQ_LOOKUP, 21'h0AAAAA, 16'h5555, 16'h8001));
    pending_reqs.push_back(mk_req(REQ_LOOKUP, 21'h055555, 16'hAAAA, 0));
    pending_reqs.push_back(mk_req(REQ_DISABLE, CODE_MAX, 16'hFFFF, 16'hFFFF));
    pending_reqs.push_back(mk_req(REQ_LOOKUP, 21'h0AAAAA, 16'h5555, 16'h8001));
    pending_reqs.push_back(mk_req(REQ_ALLOC, 21'h0AAAAA, 16'h5555, 16'h8001));
    pending_reqs.push_back(mk_req(REQ_INIT, 0, 0, 0));
    pending_reqs.push_back(mk_req(REQ_LOOKUP, 21'h0AAAAA, 16'h5555, 16'h8001));
    pending_reqs.push_back(mk_req(REQ_LOOKUP, 0, 0, 0));

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 79 : 0;
      recv_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 14 : 0;
      for (int n = 0; n < PHASE_N; n++) pending_reqs.push_back(random_req());
      while (pending_reqs.size() > 0 || s_axis_tvalid || expected_slots.size() > 0)
        @(posedge clk_i);
    end

    // tail for any stray result word
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && expected_slots.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
